/* src/pwc_pkg.sv */
// Shared types and constants for the RC pulse-width capture block.
`default_nettype none
package pwc_pkg;

  localparam int TIME_BITS  = 32;
  localparam int NUM_CH     = 5;
  localparam int CH_W       = 3;
  localparam int CH_IDX_W   = $clog2(NUM_CH);
  localparam int IN_TIME_W  = 32;
  localparam int LEN_W      = 32;
  localparam int STAMP_W    = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
  localparam int IN_DATA_W  = ((CH_W + 1 + IN_TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = NUM_CH * LEN_W;

  typedef enum logic {
    MODE_EDGE   = 1'b0,
    MODE_REPORT = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [CH_W-1:0]      channel;
    logic                 level;
    logic [IN_TIME_W-1:0] time_us;
  } pwc_req_t;

  typedef struct packed {
    logic                        rx_error;
    logic [NUM_CH-1:0][LEN_W-1:0] len;
  } pwc_res_t;

endpackage
`default_nettype wire

/* src/pwc_in_reg.sv */
// Input register that holds one accepted request for the channel bank.
`default_nettype none
module pwc_in_reg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [pwc_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                           in_tuser,
  input  wire logic                           adv,
  output logic                                req_valid,
  output pwc_pkg::pwc_req_t                   req
);
  import pwc_pkg::*;

  logic     valid_r, valid_nxt;
  pwc_req_t req_r, req_nxt;
  logic     accept;

  assign in_tready = !valid_r || adv;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    req_nxt   = req_r;
    if (accept) begin
      valid_nxt       = 1'b1;
      req_nxt.mode    = mode_t'(in_tuser);
      req_nxt.channel = in_tdata[CH_W-1:0];
      req_nxt.level   = in_tdata[CH_W];
      req_nxt.time_us = in_tdata[CH_W+1 +: IN_TIME_W];
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    req_r <= req_nxt;
  end

  assign req_valid = valid_r;
  assign req       = req_r;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> in_tready)
    else $error("input register empty but not ready");

endmodule
`default_nettype wire

/* src/pwc_chan_bank.sv */
// Per-channel rise times and pulse lengths, with the report result logic.
`default_nettype none
module pwc_chan_bank (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire pwc_pkg::pwc_req_t req,
  output pwc_pkg::pwc_res_t      res
);
  import pwc_pkg::*;

  logic [STAMP_W-1:0] rise_r   [NUM_CH];
  logic [STAMP_W-1:0] rise_nxt [NUM_CH];
  logic [STAMP_W-1:0] len_r    [NUM_CH];
  logic [STAMP_W-1:0] len_nxt  [NUM_CH];
  logic [CH_IDX_W-1:0] ch_idx;
  logic [STAMP_W-1:0] stamp;
  logic               ch_ok;
  logic               late_ok;
  logic               err;

  assign ch_idx  = req.channel[CH_IDX_W-1:0];
  assign stamp   = req.time_us[STAMP_W-1:0];
  assign ch_ok   = req.channel < CH_W'(NUM_CH);
  assign late_ok = stamp >= rise_r[ch_idx];

  always_comb begin
    rise_nxt = rise_r;
    len_nxt  = len_r;
    if (fire) begin
      if (req.mode == MODE_REPORT) begin
        for (int k = 0; k < NUM_CH; k++) begin
          len_nxt[k] = '0;
        end
      end else if (ch_ok) begin
        if (req.level) begin
          rise_nxt[ch_idx] = stamp;
        end else if (late_ok) begin
          len_nxt[ch_idx] = stamp - rise_r[ch_idx];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CH; k++) begin
        rise_r[k] <= '0;
        len_r[k]  <= '0;
      end
    end else begin
      rise_r <= rise_nxt;
      len_r  <= len_nxt;
    end
  end

  assign err = (len_r[0] == '0);

  always_comb begin
    res.rx_error = err;
    for (int k = 0; k < NUM_CH; k++) begin
      res.len[k] = err ? '0 : LEN_W'(len_r[k]);
    end
  end

  a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req.mode == MODE_REPORT |=>
      len_r[0] == '0 && len_r[1] == '0 && len_r[2] == '0 &&
      len_r[3] == '0 && len_r[4] == '0)
    else $error("pulse lengths not cleared after a report");

  a_bad_channel_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req.mode == MODE_EDGE && !ch_ok |=> $stable(len_r[0]) && $stable(rise_r[0]))
    else $error("edge on an unknown channel changed channel state");

endmodule
`default_nettype wire

/* src/pwc_out_reg.sv */
// Result register that holds one report until the receiver takes it.
`default_nettype none
module pwc_out_reg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            load,
  input  wire pwc_pkg::pwc_res_t               res,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [pwc_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tuser
);
  import pwc_pkg::*;

  logic     valid_r, valid_nxt;
  pwc_res_t res_r, res_nxt;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.len;
  assign out_tuser  = res_r.rx_error;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !valid_r || out_tready)
    else $error("result register overwritten while stalled");

  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && res_r.rx_error |-> res_r.len == '0)
    else $error("error report carries nonzero lengths");

endmodule
`default_nettype wire

/* src/rc_pulse_width_capture.sv */
// Top level of the five-channel RC pulse-width capture block.
//
// The input channel carries edge events and report requests. in_tuser selects
// the kind: 0 for an edge, 1 for a report. An edge names a channel, the new
// pin level and a microsecond timestamp; rises store the timestamp, falls
// at or after the stored rise store the pulse length. A report returns the
// five lengths on the output channel and clears them; a zero throttle length
// sets out_tuser (rx_error) and zeroes all five lengths.
// A request is registered in the input register, and a report's result is then
// registered in the output register when the report leaves the input register.
// One request is taken in every cycle. When the receiver stalls, edges keep
// flowing and only a report waiting behind a held result stops the input.
// Reset clears all rise times and lengths to zero and empties both registers.
`default_nettype none
module rc_pulse_width_capture (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // channel[2:0], level[3], time_us[35:4], zero[39:36]
  input  wire logic [pwc_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode[0]
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // throttle_len[31:0], steering_len[63:32], aux5_len[95:64],
  // aux6_len[127:96], speed_len[159:128]
  output logic [pwc_pkg::OUT_DATA_W-1:0]       out_tdata,
  // rx_error[0]
  output logic                                 out_tuser
);
  import pwc_pkg::*;

  logic     req_valid;
  pwc_req_t req;
  pwc_res_t res;
  logic     adv;
  logic     fire;
  logic     load;

  assign adv  = (req.mode == MODE_EDGE) || !out_tvalid || out_tready;
  assign fire = req_valid && adv;
  assign load = fire && (req.mode == MODE_REPORT);

  pwc_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req)
  );

  pwc_chan_bank u_chan_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req),
    .res   (res)
  );

  pwc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_report_waits: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req.mode == MODE_REPORT && out_tvalid && !out_tready |-> !fire)
    else $error("report advanced while the result register was held");

  a_report_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("report did not produce a result");

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for rc_pulse_width_capture: directed and random edge/report traffic.
module testbench;
  import pwc_pkg::*;

  typedef struct {
    mode_t       mode;
    logic [2:0]  channel;
    logic        level;
    logic [31:0] time_us;
    bit          typed;
    pwc_res_t    result;
  } stim_row_t;

  localparam pwc_res_t NO_THROTTLE = {1'b1, {OUT_DATA_W{1'b0}}};
  localparam pwc_res_t FIRST_FILL  =
    {1'b0, 32'd2000, 32'd0, 32'd0, 32'd1500, 32'hFFFF_FFFF};

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  logic [LEN_W-1:0] rise_stamp [NUM_CH];
  logic [LEN_W-1:0] pulse_len [NUM_CH];
  pwc_res_t         pending_reports [$];
  stim_row_t        directed_rows [$];
  pwc_res_t         exp_res;
  pwc_res_t         got_res;
  int               mismatches = 0;
  int               send_idle_pct = 24;
  int               recv_idle_pct = 53;

  rc_pulse_width_capture dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic bit capture_step(input mode_t m, input logic [2:0] ch, input logic lvl,
                                      input logic [31:0] t, output pwc_res_t res);
    res = '0;
    if (m == MODE_EDGE) begin
      if (ch < NUM_CH) begin
        if (lvl) begin
          rise_stamp[ch] = t;
        end else if (t >= rise_stamp[ch]) begin
          pulse_len[ch] = t - rise_stamp[ch];
        end
      end
      return 1'b0;
    end
    if (pulse_len[0] == '0) begin
      res.rx_error = 1'b1;
    end else begin
      for (int c = 0; c < NUM_CH; c++) res.len[c] = pulse_len[c];
    end
    for (int c = 0; c < NUM_CH; c++) pulse_len[c] = '0;
    return 1'b1;
  endfunction

  task automatic send_request(input mode_t m, input logic [2:0] ch, input logic lvl,
                              input logic [31:0] t, input bit typed, input pwc_res_t typed_res);
    bit ready;
    pwc_res_t res;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {4'b0, t, lvl, ch};
    do begin
      @(negedge clk);
      ready = in_tready;
      @(posedge clk);
    end while (!ready);
    if (capture_step(m, ch, lvl, t, res)) pending_reports.push_back(typed ? typed_res : res);
  endtask

  task automatic add_row(input mode_t m, input logic [2:0] ch, input logic lvl,
                         input logic [31:0] t, input bit typed, input pwc_res_t res);
    stim_row_t row;
    row.mode = m;
    row.channel = ch;
    row.level = lvl;
    row.time_us = t;
    row.typed = typed;
    row.result = res;
    directed_rows.push_back(row);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("Mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Outputs are sampled on the falling edge; the handshake completes at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = {out_tuser, out_tdata};
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected result rx_error=%0b throttle=%h",
                                got_res.rx_error, got_res.len[0]));
      end else begin
        exp_res = pending_reports.pop_front();
        if (got_res.rx_error !== exp_res.rx_error)
          flag_mismatch($sformatf("rx_error expected %0b got %0b",
                                  exp_res.rx_error, got_res.rx_error));
        for (int c = 0; c < NUM_CH; c++) begin
          if (got_res.len[c] !== exp_res.len[c])
            flag_mismatch($sformatf("len[%0d] expected %h got %h",
                                    c, exp_res.len[c], got_res.len[c]));
        end
      end
    end
  end

  initial begin
    logic [31:0] stamp_now;
    logic [31:0] width;
    logic [2:0]  ch;
    int          items;
    int          pick;
    for (int c = 0; c < NUM_CH; c++) begin
      rise_stamp[c] = '0;
      pulse_len[c] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    add_row(MODE_REPORT, 3'd0, 1'b0, 32'h0, 1'b1, NO_THROTTLE);
    add_row(MODE_EDGE, 3'd0, 1'b1, 32'h0000_0000, 1'b0, '0);
    add_row(MODE_EDGE, 3'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(MODE_EDGE, 3'd1, 1'b1, 32'd100, 1'b0, '0);
    add_row(MODE_EDGE, 3'd1, 1'b0, 32'd1600, 1'b0, '0);
    add_row(MODE_EDGE, 3'd2, 1'b1, 32'hFFFF_FFF0, 1'b0, '0);
    add_row(MODE_EDGE, 3'd2, 1'b0, 32'd5, 1'b0, '0);
    add_row(MODE_EDGE, 3'd3, 1'b1, 32'd7, 1'b0, '0);
    add_row(MODE_EDGE, 3'd3, 1'b0, 32'd7, 1'b0, '0);
    add_row(MODE_EDGE, 3'd4, 1'b1, 32'd1000, 1'b0, '0);
    add_row(MODE_EDGE, 3'd4, 1'b0, 32'd3000, 1'b0, '0);
    add_row(MODE_EDGE, 3'd4, 1'b0, 32'd999, 1'b0, '0);
    add_row(MODE_EDGE, 3'd5, 1'b1, 32'h5555_5555, 1'b0, '0);
    add_row(MODE_EDGE, 3'd6, 1'b0, 32'hAAAA_AAAA, 1'b0, '0);
    add_row(MODE_EDGE, 3'd7, 1'b0, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(MODE_REPORT, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1, FIRST_FILL);
    add_row(MODE_REPORT, 3'd0, 1'b0, 32'h0, 1'b1, NO_THROTTLE);
    add_row(MODE_EDGE, 3'd1, 1'b1, 32'd10, 1'b0, '0);
    add_row(MODE_EDGE, 3'd1, 1'b0, 32'd20, 1'b0, '0);
    add_row(MODE_REPORT, 3'd2, 1'b1, 32'h1234_5678, 1'b1, NO_THROTTLE);
    add_row(MODE_EDGE, 3'd0, 1'b1, 32'd5000, 1'b0, '0);
    add_row(MODE_EDGE, 3'd0, 1'b0, 32'd5001, 1'b0, '0);
    add_row(MODE_REPORT, 3'd5, 1'b0, 32'h8000_0000, 1'b0, '0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].channel, directed_rows[i].level,
                   directed_rows[i].time_us, directed_rows[i].typed, directed_rows[i].result);
    drain_results();

    stamp_now = $urandom;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 24 : 0;
      items = 0;
      while (items < 600) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          ch = $urandom_range(NUM_CH - 1);
          width = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2100, 900);
          send_request(MODE_EDGE, ch, 1'b1, stamp_now, 1'b0, '0);
          stamp_now = stamp_now + width;
          send_request(MODE_EDGE, ch, 1'b0, stamp_now, 1'b0, '0);
          stamp_now = stamp_now + $urandom_range(20000);
          items += 2;
        end else if (pick < 72) begin
          send_request(MODE_REPORT, 3'($urandom), 1'($urandom), $urandom, 1'b0, '0);
          items++;
        end else if (pick < 80) begin
          send_request(MODE_EDGE, 3'($urandom_range(7, NUM_CH)), 1'($urandom), $urandom,
                       1'b0, '0);
          items++;
        end else begin
          ch = $urandom_range(NUM_CH - 1);
          send_request(MODE_EDGE, ch, 1'($urandom),
                       $urandom_range(1) ? $urandom : stamp_now - $urandom_range(3000),
                       1'b0, '0);
          items++;
        end
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/pwc_pkg.sv
src/pwc_in_reg.sv
src/pwc_chan_bank.sv
src/pwc_out_reg.sv
src/rc_pulse_width_capture.sv
test/testbench.sv
